### hdl/key_autorepeat_controller_macros.svh
// assertion macros for the key autorepeat controller
`ifndef KEY_AUTOREPEAT_CONTROLLER_MACROS_SVH
`define KEY_AUTOREPEAT_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define KAC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("key autorepeat controller check failed");
`define KAC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("key autorepeat controller check failed");
`else
`define KAC_ASSERT(label, clk, rst_n, prop)
`define KAC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### hdl/kac_pkg.sv
package kac_pkg;

  localparam int DELAY_W  = 13;
  localparam int PERIOD_W = 11;
  localparam int CODE_W   = 16;
  localparam int KEY_W    = 4;
  localparam int SRC_W    = 5;
  localparam int VAL_W    = 3;
  localparam int REP_W    = 4;
  localparam int CFG_IDX_W = 1;

  localparam int RAMP_COUNT    = 8;
  localparam int MIN_PERIOD_MS = 25;

  localparam logic [DELAY_W-1:0]  DELAY_RESET  = 13'd350;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd90;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd1;

  localparam logic [1:0] REQ_KEY  = 2'd0;
  localparam logic [1:0] REQ_AXIS = 2'd1;
  localparam logic [1:0] REQ_LOST = 2'd2;
  localparam logic [1:0] REQ_TICK = 2'd3;

  localparam logic [CODE_W-1:0] HAT_X = 16'h0010;
  localparam logic [CODE_W-1:0] HAT_Y = 16'h0011;

  localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
  localparam logic [KEY_W-1:0] DIR_UP    = 4'd1;
  localparam logic [KEY_W-1:0] DIR_DOWN  = 4'd2;
  localparam logic [KEY_W-1:0] DIR_LEFT  = 4'd3;
  localparam logic [KEY_W-1:0] DIR_RIGHT = 4'd4;

  localparam logic signed [VAL_W-1:0] VAL_RELEASE = 3'sd0;
  localparam logic signed [VAL_W-1:0] VAL_PRESS   = 3'sd1;
  localparam logic signed [VAL_W-1:0] VAL_REPEAT  = 3'sd2;

  localparam logic signed [SRC_W-1:0] SRC_NONE = -5'sd1;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [CODE_W-1:0]       event_code;
    logic signed [VAL_W-1:0] event_value;
    logic signed [SRC_W-1:0] source_id;
    logic [KEY_W-1:0]        mapped_key;
    logic                    is_quit_key;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_out;
    logic             quit_request;
  } result_t;

  function automatic logic is_direction(input logic [KEY_W-1:0] k);
    return (k >= DIR_UP) && (k <= DIR_RIGHT);
  endfunction

endpackage

### hdl/kac_in_stage.sv
module kac_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kac_pkg::item_t in_item,
  input  logic           down_free,
  output logic           stage_fire,
  output kac_pkg::item_t stage_item
);

  logic           in_v_r;
  logic           in_v_nxt;
  kac_pkg::item_t item_r;

  assign in_ready   = !in_v_r || down_free;
  assign stage_fire = in_v_r && down_free;
  assign stage_item = item_r;
  assign in_v_nxt   = in_ready ? in_valid : in_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### hdl/kac_engine.sv
`include "key_autorepeat_controller_macros.svh"

module kac_engine #(
  parameter int RAMP_COUNT    = kac_pkg::RAMP_COUNT,
  parameter int MIN_PERIOD_MS = kac_pkg::MIN_PERIOD_MS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [kac_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [kac_pkg::DELAY_W-1:0]           cfg_wdata,
  input  logic                                  fire,
  input  kac_pkg::item_t                        item,
  output logic                                  res_valid,
  output kac_pkg::result_t                      res
);

  logic [kac_pkg::DELAY_W-1:0]    delay_r;
  logic [kac_pkg::PERIOD_W-1:0]   period_r;

  logic [kac_pkg::KEY_W-1:0]      held_key_r, held_key_nxt;
  logic                           held_axis_r, held_axis_nxt;
  logic [kac_pkg::CODE_W-1:0]     held_code_r, held_code_nxt;
  logic signed [kac_pkg::SRC_W-1:0] held_src_r, held_src_nxt;
  logic [kac_pkg::REP_W-1:0]      reps_r, reps_nxt;
  logic [kac_pkg::DELAY_W-1:0]    ms_r, ms_nxt;

  logic                           drop;
  logic [kac_pkg::KEY_W-1:0]      new_key;
  logic                           held;
  logic                           code_match;
  logic [kac_pkg::DELAY_W-1:0]    ms_dec;
  logic [kac_pkg::REP_W-1:0]      reps_inc;
  logic [kac_pkg::PERIOD_W-1:0]   half_period;
  logic [kac_pkg::PERIOD_W-1:0]   fast_floor;
  logic [kac_pkg::PERIOD_W-1:0]   fast_period;
  logic [kac_pkg::DELAY_W-1:0]    reload;

  assign held        = (held_key_r != kac_pkg::KEY_NONE);
  assign code_match  = held && (held_code_r == item.event_code);
  assign ms_dec      = ms_r - kac_pkg::DELAY_W'(1);
  assign reps_inc    = (reps_r < kac_pkg::REP_W'(RAMP_COUNT)) ?
                       reps_r + kac_pkg::REP_W'(1) : reps_r;
  assign half_period = period_r >> 1;
  assign fast_floor  = (half_period < kac_pkg::PERIOD_W'(MIN_PERIOD_MS)) ?
                       kac_pkg::PERIOD_W'(MIN_PERIOD_MS) : half_period;
  assign fast_period = (fast_floor > period_r) ? period_r : fast_floor;

  always_comb begin
    if (delay_r == '0) begin
      reload = '0;
    end else if (reps_inc < kac_pkg::REP_W'(RAMP_COUNT)) begin
      reload = kac_pkg::DELAY_W'(period_r);
    end else begin
      reload = kac_pkg::DELAY_W'(fast_period);
    end
  end

  always_comb begin
    held_key_nxt  = held_key_r;
    held_axis_nxt = held_axis_r;
    held_code_nxt = held_code_r;
    held_src_nxt  = held_src_r;
    reps_nxt      = reps_r;
    ms_nxt        = ms_r;
    drop          = 1'b0;
    new_key       = kac_pkg::KEY_NONE;
    res_valid     = 1'b0;
    res           = '0;
    unique case (item.req_type)
      kac_pkg::REQ_KEY: begin
        if (item.event_value == kac_pkg::VAL_RELEASE) begin
          drop = code_match && !held_axis_r;
        end else if (item.event_value == kac_pkg::VAL_PRESS && item.is_quit_key) begin
          res_valid        = 1'b1;
          res.quit_request = 1'b1;
        end else if (item.event_value == kac_pkg::VAL_PRESS ||
                     item.event_value == kac_pkg::VAL_REPEAT) begin
          if (!(item.event_value == kac_pkg::VAL_REPEAT &&
                kac_pkg::is_direction(item.mapped_key))) begin
            new_key = item.mapped_key;
          end
        end
      end
      kac_pkg::REQ_AXIS: begin
        if (item.event_value == kac_pkg::VAL_RELEASE) begin
          drop = code_match && held_axis_r;
        end else if (item.event_code == kac_pkg::HAT_X) begin
          new_key = item.event_value[kac_pkg::VAL_W-1] ?
                    kac_pkg::DIR_LEFT : kac_pkg::DIR_RIGHT;
        end else if (item.event_code == kac_pkg::HAT_Y) begin
          new_key = item.event_value[kac_pkg::VAL_W-1] ?
                    kac_pkg::DIR_UP : kac_pkg::DIR_DOWN;
        end
      end
      kac_pkg::REQ_LOST: begin
        drop = !item.source_id[kac_pkg::SRC_W-1] && (held_src_r == item.source_id);
      end
      kac_pkg::REQ_TICK: begin
        if (held && ms_r != '0) begin
          if (ms_dec != '0) begin
            ms_nxt = ms_dec;
          end else begin
            reps_nxt    = reps_inc;
            ms_nxt      = reload;
            res_valid   = 1'b1;
            res.key_out = held_key_r;
          end
        end
      end
      default: begin
      end
    endcase
    if (new_key != kac_pkg::KEY_NONE) begin
      res_valid   = 1'b1;
      res.key_out = new_key;
      if (kac_pkg::is_direction(new_key) && delay_r != '0) begin
        held_key_nxt  = new_key;
        held_axis_nxt = (item.req_type == kac_pkg::REQ_AXIS);
        held_code_nxt = item.event_code;
        held_src_nxt  = item.source_id;
        reps_nxt      = '0;
        ms_nxt        = delay_r;
      end else begin
        drop = 1'b1;
      end
    end
    if (drop) begin
      held_key_nxt  = kac_pkg::KEY_NONE;
      held_axis_nxt = 1'b0;
      held_code_nxt = '0;
      held_src_nxt  = kac_pkg::SRC_NONE;
      reps_nxt      = '0;
      ms_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= kac_pkg::DELAY_RESET;
      period_r <= kac_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kac_pkg::CFG_DELAY:  delay_r  <= cfg_wdata;
        kac_pkg::CFG_PERIOD: period_r <= cfg_wdata[kac_pkg::PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_key_r  <= kac_pkg::KEY_NONE;
      held_axis_r <= 1'b0;
      held_code_r <= '0;
      held_src_r  <= kac_pkg::SRC_NONE;
      reps_r      <= '0;
      ms_r        <= '0;
    end else if (fire) begin
      held_key_r  <= held_key_nxt;
      held_axis_r <= held_axis_nxt;
      held_code_r <= held_code_nxt;
      held_src_r  <= held_src_nxt;
      reps_r      <= reps_nxt;
      ms_r        <= ms_nxt;
    end
  end

  // nothing held means the whole hold record sits at its idle value
  `KAC_ASSERT(a_idle_hold_clean, clk, rst_n, !held |-> (ms_r == '0 && reps_r == '0 && held_src_r == kac_pkg::SRC_NONE && !held_axis_r && held_code_r == '0))
  `KAC_ASSERT(a_held_is_direction, clk, rst_n, held |-> kac_pkg::is_direction(held_key_r))
  `KAC_ASSERT(a_ramp_saturates, clk, rst_n, reps_r <= kac_pkg::REP_W'(RAMP_COUNT))
  // state only moves when a beat is consumed
  `KAC_ASSERT(a_state_holds_when_idle, clk, rst_n, !fire |=> ($stable(held_key_r) && $stable(ms_r) && $stable(reps_r)))

endmodule

### hdl/kac_out_reg.sv
`include "key_autorepeat_controller_macros.svh"

module kac_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  kac_pkg::result_t load_res,
  output logic             down_free,
  output logic             out_valid,
  input  logic             out_ready,
  output kac_pkg::result_t out_res
);

  logic             out_v_r;
  logic             out_v_nxt;
  kac_pkg::result_t res_r;

  assign down_free = !out_v_r || out_ready;
  assign out_valid = out_v_r;
  assign out_res   = res_r;
  assign out_v_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  // a quit beat never carries a key
  `KAC_ASSERT(a_quit_has_no_key, clk, rst_n, (out_v_r && res_r.quit_request) |-> (res_r.key_out == kac_pkg::KEY_NONE))

endmodule

### hdl/key_autorepeat_controller.sv
// key autorepeat controller
// input channel (in_valid/in_ready): one beat per key event, hat-axis move,
// device-lost notice or 1 ms tick; the type sits on in_req_type.
// output channel (out_valid/out_ready): zero or one beat per input beat,
// carrying a key for the UI or a quit request, in input order.
// config port: cfg_we with cfg_index 0 writes the initial delay, index 1 the
// repeat period; write only while no beat is in flight.
// an accepted beat is captured in the input register; once the output register
// is free, its result is loaded there and held until out_ready takes it.
// throughput: one beat per cycle while the output register is free or being
// drained; the hold/timer update between the input and output registers is combinational.
// when out_ready stays low the finished result holds in the output register
// and one more beat may wait in the input register; in_ready then drops.
// reset (rst_n low, synchronous) empties both registers, drops any hold,
// disarms the timer and loads delay 350 ms and period 90 ms.
module key_autorepeat_controller #(
  parameter int RAMP_COUNT    = kac_pkg::RAMP_COUNT,
  parameter int MIN_PERIOD_MS = kac_pkg::MIN_PERIOD_MS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_req_type,
  input  logic [kac_pkg::CODE_W-1:0]          in_event_code,
  input  logic signed [kac_pkg::VAL_W-1:0]    in_event_value,
  input  logic signed [kac_pkg::SRC_W-1:0]    in_source_id,
  input  logic [kac_pkg::KEY_W-1:0]           in_mapped_key,
  input  logic                                in_is_quit_key,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [kac_pkg::KEY_W-1:0]           out_key_out,
  output logic                                out_quit_request,
  input  logic                                cfg_we,
  input  logic [kac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kac_pkg::DELAY_W-1:0]         cfg_wdata
);

  kac_pkg::item_t   in_item;
  kac_pkg::item_t   stage_item;
  kac_pkg::result_t eng_res;
  kac_pkg::result_t out_res;
  logic             stage_fire;
  logic             down_free;
  logic             eng_res_valid;

  assign in_item.req_type    = in_req_type;
  assign in_item.event_code  = in_event_code;
  assign in_item.event_value = in_event_value;
  assign in_item.source_id   = in_source_id;
  assign in_item.mapped_key  = in_mapped_key;
  assign in_item.is_quit_key = in_is_quit_key;

  kac_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .down_free  (down_free),
    .stage_fire (stage_fire),
    .stage_item (stage_item)
  );

  kac_engine #(
    .RAMP_COUNT    (RAMP_COUNT),
    .MIN_PERIOD_MS (MIN_PERIOD_MS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (stage_fire),
    .item      (stage_item),
    .res_valid (eng_res_valid),
    .res       (eng_res)
  );

  kac_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (stage_fire && eng_res_valid),
    .load_res  (eng_res),
    .down_free (down_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_key_out      = out_res.key_out;
  assign out_quit_request = out_res.quit_request;

endmodule

### tb/key_autorepeat_checker.sv
`timescale 1ns / 1ps
module key_autorepeat_checker
  import kac_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                in_req_type,
  input  logic [CODE_W-1:0]         in_event_code,
  input  logic signed [VAL_W-1:0]   in_event_value,
  input  logic signed [SRC_W-1:0]   in_source_id,
  input  logic [KEY_W-1:0]          in_mapped_key,
  input  logic                      in_is_quit_key,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [KEY_W-1:0]          out_key_out,
  input  logic                      out_quit_request,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [DELAY_W-1:0]        cfg_wdata,
  output int                        fail_count,
  output int                        pending
);

  logic [DELAY_W-1:0]      delay_ms;
  logic [PERIOD_W-1:0]     period_ms;
  logic [KEY_W-1:0]        held_key;
  logic                    held_axis;
  logic [CODE_W-1:0]       held_code;
  logic signed [SRC_W-1:0] held_src;
  logic [REP_W-1:0]        repeat_cnt;
  logic [DELAY_W-1:0]      ms_left;

  result_t key_queue[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic logic is_arrow(input logic [KEY_W-1:0] k);
    return (k >= DIR_UP) && (k <= DIR_RIGHT);
  endfunction

  function automatic logic [DELAY_W-1:0] reload_for(input logic [REP_W-1:0] n);
    int fast;
    logic [DELAY_W-1:0] r;
    if (delay_ms == '0) return '0;
    if (n == 0) return delay_ms;
    r = DELAY_W'(period_ms);
    if (n < RAMP_COUNT) return r;
    fast = period_ms / 2;
    if (fast < MIN_PERIOD_MS) fast = MIN_PERIOD_MS;
    if (fast > period_ms) fast = period_ms;
    r = DELAY_W'(fast);
    return r;
  endfunction

  task automatic clear_hold();
    if (held_key == KEY_NONE) return;
    held_key = KEY_NONE;
    held_axis = 1'b0;
    held_code = '0;
    held_src = SRC_NONE;
    repeat_cnt = '0;
    ms_left = '0;
  endtask

  function automatic logic hold_matches(input logic axis, input logic [CODE_W-1:0] code);
    return (held_key != KEY_NONE) && (held_axis == axis) && (held_code == code);
  endfunction

  task automatic start_hold(input logic [KEY_W-1:0] key, input logic axis,
                            input logic [CODE_W-1:0] code, input logic signed [SRC_W-1:0] src);
    if (!is_arrow(key) || reload_for('0) == '0) begin
      clear_hold();
      return;
    end
    held_key = key;
    held_axis = axis;
    held_code = code;
    held_src = src;
    repeat_cnt = '0;
    ms_left = reload_for('0);
  endtask

  task automatic apply_event(input item_t it, output logic fires, output result_t res);
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] v;
    logic signed [SRC_W-1:0] s;
    fires = 1'b0;
    res = '0;
    key = KEY_NONE;
    v = it.event_value;
    s = it.source_id;
    case (it.req_type)
      REQ_KEY: begin
        if (v == VAL_RELEASE) begin
          if (hold_matches(1'b0, it.event_code)) clear_hold();
          return;
        end
        if (v == VAL_PRESS) begin
          if (it.is_quit_key) begin
            fires = 1'b1;
            res.key_out = KEY_NONE;
            res.quit_request = 1'b1;
            return;
          end
        end else if (v != VAL_REPEAT) begin
          return;
        end
        key = it.mapped_key;
        if (v == VAL_REPEAT && is_arrow(key)) return;
      end
      REQ_AXIS: begin
        if (v == VAL_RELEASE) begin
          if (hold_matches(1'b1, it.event_code)) clear_hold();
          return;
        end
        if (it.event_code == HAT_X) key = (v < 0) ? DIR_LEFT : DIR_RIGHT;
        else if (it.event_code == HAT_Y) key = (v < 0) ? DIR_UP : DIR_DOWN;
        else return;
      end
      REQ_LOST: begin
        if (s >= 0 && held_src == s) clear_hold();
        return;
      end
      default: begin
        if (held_key == KEY_NONE || ms_left == '0) return;
        ms_left--;
        if (ms_left != '0) return;
        if (repeat_cnt < RAMP_COUNT) repeat_cnt++;
        ms_left = reload_for(repeat_cnt);
        fires = 1'b1;
        res.key_out = held_key;
        res.quit_request = 1'b0;
        return;
      end
    endcase
    if (key == KEY_NONE) return;
    start_hold(key, it.req_type == REQ_AXIS, it.event_code, s);
    fires = 1'b1;
    res.key_out = key;
    res.quit_request = 1'b0;
  endtask

  always @(posedge clk) begin : watch
    item_t   it;
    result_t want;
    result_t res;
    logic    fires;
    if (!rst_n) begin
      delay_ms = DELAY_RESET;
      period_ms = PERIOD_RESET;
      held_key = KEY_NONE;
      held_axis = 1'b0;
      held_code = '0;
      held_src = SRC_NONE;
      repeat_cnt = '0;
      ms_left = '0;
      key_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (key_queue.size() == 0) begin
          flag_mismatch("unexpected beat, key_out", int'(out_key_out), 0);
        end else begin
          want = key_queue.pop_front();
          if (out_key_out !== want.key_out)
            flag_mismatch("key_out", int'(out_key_out), int'(want.key_out));
          if (out_quit_request !== want.quit_request)
            flag_mismatch("quit_request", int'(out_quit_request),
                          int'(want.quit_request));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DELAY:  delay_ms = cfg_wdata;
          CFG_PERIOD: period_ms = cfg_wdata[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        it.req_type = in_req_type;
        it.event_code = in_event_code;
        it.event_value = in_event_value;
        it.source_id = in_source_id;
        it.mapped_key = in_mapped_key;
        it.is_quit_key = in_is_quit_key;
        apply_event(it, fires, res);
        if (fires) key_queue.push_back(res);
      end
    end
    pending = key_queue.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import kac_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_req_type = REQ_TICK;
  logic [CODE_W-1:0]       in_event_code = '0;
  logic signed [VAL_W-1:0] in_event_value = '0;
  logic signed [SRC_W-1:0] in_source_id = '0;
  logic [KEY_W-1:0]        in_mapped_key = '0;
  logic                    in_is_quit_key = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [KEY_W-1:0]        out_key_out;
  logic                    out_quit_request;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [DELAY_W-1:0]      cfg_wdata = '0;

  int fail_count;
  int pending;
  int send_idle = 29;
  int recv_idle = 85;
  int sent_beats = 0;
  int cycle_count = 0;
  bit stall_req = 1'b0;

  key_autorepeat_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_event_code(in_event_code),
    .in_event_value(in_event_value), .in_source_id(in_source_id),
    .in_mapped_key(in_mapped_key), .in_is_quit_key(in_is_quit_key),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_key_out(out_key_out), .out_quit_request(out_quit_request),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  key_autorepeat_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_event_code(in_event_code),
    .in_event_value(in_event_value), .in_source_id(in_source_id),
    .in_mapped_key(in_mapped_key), .in_is_quit_key(in_is_quit_key),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_key_out(out_key_out), .out_quit_request(out_quit_request),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver, with a long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (stall_req && hold_left == 0) begin
        hold_left = 60;
        stall_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic item_t mk(input logic [1:0] kind, input logic [CODE_W-1:0] code,
                               input logic signed [VAL_W-1:0] val,
                               input logic signed [SRC_W-1:0] src,
                               input logic [KEY_W-1:0] mkey, input logic quit);
    item_t it;
    it.req_type = kind;
    it.event_code = code;
    it.event_value = val;
    it.source_id = src;
    it.mapped_key = mkey;
    it.is_quit_key = quit;
    return it;
  endfunction

  function automatic item_t noise_beat();
    return mk(2'($urandom_range(3)), CODE_W'($urandom), VAL_W'($urandom), SRC_W'($urandom),
              KEY_W'($urandom), 1'($urandom));
  endfunction

  function automatic item_t tick_beat();
    return mk(REQ_TICK, CODE_W'($urandom), VAL_W'($urandom), SRC_W'($urandom),
              KEY_W'($urandom), 1'($urandom));
  endfunction

  task automatic send_beat(input item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req_type;
    in_event_code <= it.event_code;
    in_event_value <= it.event_value;
    in_source_id <= it.source_id;
    in_mapped_key <= it.mapped_key;
    in_is_quit_key <= it.is_quit_key;
    do @(posedge clk); while (!in_ready);
    sent_beats++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // press a direction, hold it for a run of ticks, then maybe end the hold some way
  task automatic hold_sequence(input int lo, input int hi);
    item_t                   press;
    logic signed [SRC_W-1:0] src;
    int                      n;
    src = ($urandom_range(99) < 20) ? SRC_NONE : SRC_W'($urandom_range(0, 3));
    if ($urandom_range(1))
      press = mk(REQ_AXIS, $urandom_range(1) ? HAT_X : HAT_Y, VAL_W'($urandom_range(1, 7)),
                 src, KEY_W'($urandom), 1'($urandom));
    else
      press = mk(REQ_KEY, $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(103, 108)),
                 VAL_PRESS, src, KEY_W'($urandom_range(1, 4)), 1'b0);
    send_beat(press);
    n = $urandom_range(lo, hi);
    repeat (n) begin
      if ($urandom_range(99) < 4) send_beat(noise_beat());
      else send_beat(tick_beat());
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4: send_beat(mk(press.req_type, press.event_code, VAL_RELEASE,
                                  SRC_W'($urandom), KEY_W'($urandom), 1'($urandom)));
      5, 6: send_beat(mk(REQ_LOST, CODE_W'($urandom), VAL_W'($urandom),
                         ($urandom_range(99) < 70) ? src : SRC_W'($urandom),
                         KEY_W'($urandom), 1'($urandom)));
      7: send_beat(mk(REQ_KEY, CODE_W'($urandom), VAL_PRESS, SRC_W'($urandom),
                      KEY_W'($urandom), 1'($urandom)));
      default: ;
    endcase
  endtask

  task automatic run_phase(input int beats, input int max_run);
    int start;
    start = sent_beats;
    while (sent_beats - start < beats) begin
      if ($urandom_range(99) < 25) send_beat(noise_beat());
      else hold_sequence(0, max_run);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: quit, ignored values and kernel repeat during a hold
    send_beat(mk(REQ_KEY, 16'h0067, VAL_PRESS, 5'sd0, DIR_UP, 1'b0));
    send_beat(mk(REQ_TICK, 16'h0000, 3'sd0, 5'sd0, 4'd0, 1'b0));
    send_beat(mk(REQ_KEY, 16'h0001, VAL_PRESS, 5'sd15, 4'd9, 1'b1));
    send_beat(mk(REQ_KEY, 16'h0067, -3'sd1, 5'sd0, DIR_DOWN, 1'b0));
    send_beat(mk(REQ_KEY, 16'h0067, 3'sd3, 5'sd0, DIR_DOWN, 1'b1));
    send_beat(mk(REQ_KEY, 16'h0067, -3'sd4, 5'sd0, DIR_DOWN, 1'b0));
    send_beat(mk(REQ_KEY, 16'h0030, VAL_PRESS, 5'sd1, KEY_NONE, 1'b0));
    send_beat(mk(REQ_KEY, 16'h0067, VAL_REPEAT, 5'sd0, DIR_UP, 1'b0));
    send_beat(mk(REQ_KEY, 16'h0068, VAL_RELEASE, 5'sd0, DIR_UP, 1'b0));
    send_beat(mk(REQ_KEY, 16'hffff, VAL_REPEAT, -5'sd16, 4'd15, 1'b0));
    settle();
    write_reg(CFG_DELAY, 13'd2);
    write_reg(CFG_PERIOD, {2'b11, 11'd3});

    // hat moves, release and device-loss ownership
    send_beat(mk(REQ_AXIS, HAT_X, -3'sd1, 5'sd3, 4'd0, 1'b0));
    send_beat(mk(REQ_AXIS, 16'h0012, 3'sd1, 5'sd3, 4'd0, 1'b0));
    send_beat(mk(REQ_AXIS, HAT_Y, VAL_RELEASE, 5'sd3, 4'd0, 1'b0));
    send_beat(mk(REQ_KEY, HAT_X, VAL_RELEASE, 5'sd3, DIR_LEFT, 1'b0));
    send_beat(mk(REQ_TICK, 16'h0000, 3'sd0, 5'sd0, 4'd0, 1'b0));
    send_beat(mk(REQ_TICK, 16'h0000, 3'sd0, 5'sd0, 4'd0, 1'b0));
    send_beat(mk(REQ_LOST, 16'h0000, 3'sd0, 5'sd3, 4'd0, 1'b0));
    send_beat(mk(REQ_AXIS, HAT_Y, 3'sd3, SRC_NONE, 4'd0, 1'b0));
    send_beat(mk(REQ_LOST, 16'h0000, 3'sd0, SRC_NONE, 4'd0, 1'b0));
    send_beat(mk(REQ_AXIS, HAT_Y, VAL_RELEASE, 5'sd9, 4'd0, 1'b0));
    send_beat(mk(REQ_KEY, 16'h0000, VAL_PRESS, 5'sd15, DIR_RIGHT, 1'b0));
    send_beat(mk(REQ_KEY, 16'h0000, VAL_PRESS, 5'sd15, DIR_DOWN, 1'b0));
    settle();

    // delay cleared while a direction is held
    write_reg(CFG_DELAY, 13'd0);
    send_beat(mk(REQ_TICK, 16'h0000, 3'sd0, 5'sd0, 4'd0, 1'b0));
    send_beat(mk(REQ_TICK, 16'h0000, 3'sd0, 5'sd0, 4'd0, 1'b0));
    send_beat(mk(REQ_AXIS, HAT_X, 3'sd2, 5'sd1, 4'd0, 1'b0));
    settle();

    // zero period disarms after the first repeat
    write_reg(CFG_DELAY, 13'd1);
    write_reg(CFG_PERIOD, 13'd0);
    send_beat(mk(REQ_KEY, 16'h0069, VAL_PRESS, 5'sd2, DIR_LEFT, 1'b0));
    send_beat(mk(REQ_TICK, 16'h0000, 3'sd0, 5'sd0, 4'd0, 1'b0));
    send_beat(mk(REQ_TICK, 16'h0000, 3'sd0, 5'sd0, 4'd0, 1'b0));
    settle();

    send_idle = 29;
    recv_idle = 85;
    write_reg(CFG_DELAY, 13'd3);
    write_reg(CFG_PERIOD, 13'd10);
    run_phase(150, 100);
    settle();

    send_idle = 85;
    recv_idle = 29;
    write_reg(CFG_DELAY, 13'd5000);
    write_reg(CFG_PERIOD, 13'd2000);
    run_phase(40, 30);
    settle();
    write_reg(CFG_DELAY, 13'd1);
    write_reg(CFG_PERIOD, 13'd20);
    run_phase(100, 200);
    settle();

    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_DELAY, 13'd2);
    write_reg(CFG_PERIOD, 13'd52);
    hold_sequence(440, 480);
    run_phase(60, 120);

    // long receiver stall while presses keep coming
    stall_req = 1'b1;
    repeat (20) send_beat(mk(REQ_KEY, CODE_W'($urandom), VAL_PRESS, SRC_W'($urandom),
                             KEY_W'($urandom_range(5, 15)), 1'($urandom)));
    settle();

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
